// ----- design/rlwq_pkg.sv -----
// Shared constants, types and helpers for the resource lock manager.
package rlwq_pkg;

    localparam int NUM_RESOURCES   = 5;
    localparam int QUEUE_DEPTH     = 16;
    localparam int PROCESS_ID_BITS = 8;

    localparam int RES_IN_W = 3;
    localparam int PID_IN_W = 8;
    localparam int PID_W    = (PROCESS_ID_BITS < PID_IN_W) ? PROCESS_ID_BITS : PID_IN_W;
    localparam int TBL_AW   = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int SLOT_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int WAIT_DEPTH = NUM_RESOURCES * QUEUE_DEPTH;
    localparam int WAIT_AW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_INVALID   = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_OWNER = 2'd3;

    typedef struct packed {
        logic               busy;
        logic [PID_W-1:0]   owner;
        logic [SLOT_W-1:0]  head;
        logic [SLOT_W-1:0]  tail;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic                granted;
        logic                blocked;
        logic                wake_valid;
        logic [PID_IN_W-1:0] wake_id;
        logic [1:0]          status;
    } result_t;

    typedef struct packed {
        result_t result;
        logic    wake;
        logic    tbl_we;
        logic    enq;
        entry_t  entry;
    } plan_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] r;
        if (slot == SLOT_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = slot + SLOT_W'(1);
        return r;
    endfunction

    function automatic logic [WAIT_AW-1:0] wait_addr(input logic [TBL_AW-1:0] res,
                                                     input logic [SLOT_W-1:0] slot);
        return WAIT_AW'(res) * WAIT_AW'(QUEUE_DEPTH) + WAIT_AW'(slot);
    endfunction

    function automatic logic [PID_IN_W-1:0] widen_pid(input logic [PID_W-1:0] pid);
        logic [PID_IN_W-1:0] r;
        r = '0;
        r[PID_W-1:0] = pid;
        return r;
    endfunction

endpackage

// ----- design/rlwq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rlwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/rlwq_update.sv -----
// Decision logic: turns one resource entry and one operation into a new entry and a result.
module rlwq_update (
    input  logic                         op,
    input  logic                         res_ok,
    input  logic [rlwq_pkg::PID_W-1:0]   pid,
    input  rlwq_pkg::entry_t             entry,
    output rlwq_pkg::plan_t              plan
);

    always_comb
    begin
        plan = '0;
        plan.entry = entry;
        plan.result.status = rlwq_pkg::STAT_OK;
        if (!res_ok)
        begin
            plan.result.status = rlwq_pkg::STAT_INVALID;
        end
        else if (op == rlwq_pkg::OP_REQUEST)
        begin
            if (!entry.busy)
            begin
                plan.entry.busy = 1'b1;
                plan.entry.owner = pid;
                plan.result.granted = 1'b1;
                plan.tbl_we = 1'b1;
            end
            else if (entry.owner == pid)
            begin
                plan.result.granted = 1'b1;
            end
            else if (entry.count == rlwq_pkg::COUNT_W'(rlwq_pkg::QUEUE_DEPTH))
            begin
                plan.result.status = rlwq_pkg::STAT_FULL;
            end
            else
            begin
                plan.entry.tail = rlwq_pkg::next_slot(entry.tail);
                plan.entry.count = entry.count + rlwq_pkg::COUNT_W'(1);
                plan.result.blocked = 1'b1;
                plan.enq = 1'b1;
                plan.tbl_we = 1'b1;
            end
        end
        else
        begin
            if (!entry.busy || entry.owner != pid)
            begin
                plan.result.status = rlwq_pkg::STAT_NOT_OWNER;
            end
            else if (entry.count != '0)
            begin
                plan.entry.head = rlwq_pkg::next_slot(entry.head);
                plan.entry.count = entry.count - rlwq_pkg::COUNT_W'(1);
                plan.wake = 1'b1;
            end
            else
            begin
                plan.entry.busy = 1'b0;
                plan.entry.owner = '0;
                plan.tbl_we = 1'b1;
            end
        end
    end

endmodule

// ----- design/resource_lock_with_wait_queues_core.sv -----
// Lock manager top level: resource table, waiter queue store and sequencer.
// A taken word passes lookup, wake (waking release only, waiter store read) and emit states.
// Emit waits while an untaken result holds the output register; s_tready is high only in idle,
// so no new word is taken before the last one is done.
// A new word is taken while the previous result still waits in the output register.
// Reset clears the sequencer, output valid and the table valid bits (all resources free).
module resource_lock_with_wait_queues_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // req_type, resource[2:0], process_id[7:0], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // granted, blocked, wake_valid, wake_id[7:0], status[1:0], pad
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_WAKE   = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [rlwq_pkg::NUM_RESOURCES-1:0] valid_reg, valid_next;
    logic op_reg, op_next;
    logic res_ok_reg, res_ok_next;
    logic [rlwq_pkg::TBL_AW-1:0] res_reg, res_next;
    logic [rlwq_pkg::PID_W-1:0] pid_reg, pid_next;
    rlwq_pkg::entry_t entry_reg, entry_next;
    rlwq_pkg::result_t result_reg, result_next;
    rlwq_pkg::result_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic in_op;
    logic [rlwq_pkg::RES_IN_W-1:0] in_res;
    logic [rlwq_pkg::PID_IN_W-1:0] in_pid;
    logic in_res_ok;

    logic tbl_we;
    logic [rlwq_pkg::TBL_AW-1:0] tbl_raddr;
    rlwq_pkg::entry_t tbl_wdata, tbl_rdata, cur_entry;
    logic wq_we;
    logic [rlwq_pkg::WAIT_AW-1:0] wq_waddr, wq_raddr;
    logic [rlwq_pkg::PID_W-1:0] wq_rdata;
    rlwq_pkg::plan_t plan;

    assign in_op  = s_tdata[0];
    assign in_res = s_tdata[3:1];
    assign in_pid = s_tdata[11:4];
    assign in_res_ok = ({1'b0, in_res} < (rlwq_pkg::RES_IN_W + 1)'(rlwq_pkg::NUM_RESOURCES));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.status, out_reg.wake_id, out_reg.wake_valid,
                       out_reg.blocked, out_reg.granted};

    assign tbl_raddr = in_res_ok ? in_res[rlwq_pkg::TBL_AW-1:0] : '0;
    assign cur_entry = valid_reg[res_reg] ? tbl_rdata : '0;

    rlwq_ram #(
        .WIDTH ($bits(rlwq_pkg::entry_t)),
        .DEPTH (rlwq_pkg::NUM_RESOURCES)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (res_reg),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    rlwq_ram #(
        .WIDTH (rlwq_pkg::PID_W),
        .DEPTH (rlwq_pkg::WAIT_DEPTH)
    ) u_waiters (
        .clk   (clk),
        .we    (wq_we),
        .waddr (wq_waddr),
        .wdata (pid_reg),
        .raddr (wq_raddr),
        .rdata (wq_rdata)
    );

    rlwq_update u_update (
        .op     (op_reg),
        .res_ok (res_ok_reg),
        .pid    (pid_reg),
        .entry  (cur_entry),
        .plan   (plan)
    );

    assign wq_waddr = rlwq_pkg::wait_addr(res_reg, cur_entry.tail);
    assign wq_raddr = rlwq_pkg::wait_addr(res_reg, cur_entry.head);

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        op_next        = op_reg;
        res_ok_next    = res_ok_reg;
        res_next       = res_reg;
        pid_next       = pid_reg;
        entry_next     = entry_reg;
        result_next    = result_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        tbl_we         = 1'b0;
        tbl_wdata      = plan.entry;
        wq_we          = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = in_op;
                    res_ok_next = in_res_ok;
                    res_next    = tbl_raddr;
                    pid_next    = in_pid[rlwq_pkg::PID_W-1:0];
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                result_next = plan.result;
                if (plan.wake)
                begin
                    entry_next = plan.entry;
                    state_next = ST_WAKE;
                end
                else
                begin
                    tbl_we = plan.tbl_we;
                    wq_we  = plan.enq;
                    if (plan.tbl_we)
                    begin
                        valid_next[res_reg] = 1'b1;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_WAKE:
            begin
                tbl_wdata       = entry_reg;
                tbl_wdata.owner = wq_rdata;
                tbl_we          = 1'b1;
                valid_next[res_reg]    = 1'b1;
                result_next.wake_valid = 1'b1;
                result_next.wake_id    = rlwq_pkg::widen_pid(wq_rdata);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = result_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        res_ok_reg <= res_ok_next;
        res_reg    <= res_next;
        pid_reg    <= pid_next;
        entry_reg  <= entry_next;
        result_reg <= result_next;
        out_reg    <= out_next;
    end

endmodule

// ----- design/rlwq_checker.sv -----
// Port-level assertions for the lock manager top level, with its bind.
module rlwq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && !(m_tdata[0] && m_tdata[2])
                     && !(m_tdata[1] && m_tdata[2]))
        else $error("more than one outcome flag set");

    a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[12:11] == rlwq_pkg::STAT_OK)
        else $error("wake reported with non-ok status");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in progress");

    a_nowake_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[10:3] == 8'd0)
        else $error("wake id set without wake");

endmodule

bind resource_lock_with_wait_queues_core rlwq_checker u_checker (.*);

// ----- sim/resource_lock_with_wait_queues_core_tb.sv -----
// Self-checking testbench for the resource lock manager: directed and random lock traffic.
module resource_lock_with_wait_queues_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 12;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    logic                       lock_busy    [rlwq_pkg::NUM_RESOURCES];
    logic [rlwq_pkg::PID_W-1:0] lock_owner   [rlwq_pkg::NUM_RESOURCES];
    logic [rlwq_pkg::PID_W-1:0] waiter_ids   [rlwq_pkg::NUM_RESOURCES][rlwq_pkg::QUEUE_DEPTH];
    int                         waiter_head  [rlwq_pkg::NUM_RESOURCES];
    int                         waiter_tail  [rlwq_pkg::NUM_RESOURCES];
    int                         waiter_count [rlwq_pkg::NUM_RESOURCES];

    rlwq_pkg::result_t lock_results[$];
    logic [7:0]        pid_pool[POOL_SIZE];
    int                mismatches;
    int unsigned       cycle_count;
    bit                idle_on;
    int                stall_left;

    resource_lock_with_wait_queues_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rlwq_pkg::result_t arbitrate_lock(logic op, logic [2:0] res,
                                                         logic [7:0] pid);
        rlwq_pkg::result_t          r;
        logic [rlwq_pkg::PID_W-1:0] id;
        logic [rlwq_pkg::PID_W-1:0] next_owner;
        int                         ri;
        r  = '0;
        id = pid[rlwq_pkg::PID_W-1:0];
        ri = res;
        if (ri >= rlwq_pkg::NUM_RESOURCES)
        begin
            r.status = rlwq_pkg::STAT_INVALID;
        end
        else if (op == rlwq_pkg::OP_REQUEST)
        begin
            if (!lock_busy[ri])
            begin
                lock_busy[ri]  = 1'b1;
                lock_owner[ri] = id;
                r.granted      = 1'b1;
            end
            else if (lock_owner[ri] == id)
            begin
                r.granted = 1'b1;
            end
            else if (waiter_count[ri] >= rlwq_pkg::QUEUE_DEPTH)
            begin
                r.status = rlwq_pkg::STAT_FULL;
            end
            else
            begin
                waiter_ids[ri][waiter_tail[ri]] = id;
                waiter_tail[ri]  = (waiter_tail[ri] + 1) % rlwq_pkg::QUEUE_DEPTH;
                waiter_count[ri] = waiter_count[ri] + 1;
                r.blocked        = 1'b1;
            end
        end
        else
        begin
            if (!lock_busy[ri] || lock_owner[ri] != id)
            begin
                r.status = rlwq_pkg::STAT_NOT_OWNER;
            end
            else if (waiter_count[ri] > 0)
            begin
                next_owner       = waiter_ids[ri][waiter_head[ri]];
                waiter_head[ri]  = (waiter_head[ri] + 1) % rlwq_pkg::QUEUE_DEPTH;
                waiter_count[ri] = waiter_count[ri] - 1;
                lock_owner[ri]   = next_owner;
                r.wake_valid     = 1'b1;
                r.wake_id        = rlwq_pkg::PID_IN_W'(next_owner);
            end
            else
            begin
                lock_busy[ri]  = 1'b0;
                lock_owner[ri] = '0;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
                 what, cycle_count, got, want);
        mismatches++;
    endtask

    // hold the word until taken, then log its predicted result
    task automatic send_word(logic op, logic [2:0] res, logic [7:0] pid);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, pid, res, op};
        do @(posedge clk); while (!s_tready);
        lock_results.push_back(arbitrate_lock(op, res, pid));
    endtask

    task automatic run_traffic(int items, int hot, int release_pct);
        logic       op;
        logic [2:0] res;
        logic [7:0] pid;
        int         roll;
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                res = 3'($urandom_range(rlwq_pkg::NUM_RESOURCES, 7));
            else if (hot >= 0 && $urandom_range(0, 3) != 0)
                res = 3'(hot);
            else
                res = 3'($urandom_range(0, rlwq_pkg::NUM_RESOURCES - 1));
            roll = $urandom_range(0, 99);
            pid  = pid_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (res < rlwq_pkg::NUM_RESOURCES && roll < release_pct && lock_busy[res])
            begin
                op = rlwq_pkg::OP_RELEASE;
                if ($urandom_range(0, 9) != 0)
                    pid = 8'(lock_owner[res]);
            end
            else if (roll < release_pct + 5)
            begin
                op = rlwq_pkg::OP_RELEASE;
            end
            else
            begin
                op = rlwq_pkg::OP_REQUEST;
                if ($urandom_range(0, 9) == 0)
                    pid = 8'($urandom_range(0, 255));
            end
            send_word(op, res, pid);
        end
    endtask

    task automatic test_invalid_resource();
        send_word(rlwq_pkg::OP_REQUEST, 3'd5, 8'h00);
        send_word(rlwq_pkg::OP_RELEASE, 3'd6, 8'hFF);
        send_word(rlwq_pkg::OP_REQUEST, 3'd7, 8'hA5);
    endtask

    task automatic test_grant_and_regrant();
        send_word(rlwq_pkg::OP_REQUEST, 3'd0, 8'h00);
        send_word(rlwq_pkg::OP_REQUEST, 3'd0, 8'h00);
        send_word(rlwq_pkg::OP_REQUEST, 3'd4, 8'hFF);
        send_word(rlwq_pkg::OP_REQUEST, 3'd4, 8'h12);
        send_word(rlwq_pkg::OP_REQUEST, 3'd4, 8'h12);
    endtask

    task automatic test_release_paths();
        send_word(rlwq_pkg::OP_RELEASE, 3'd1, 8'h33);
        send_word(rlwq_pkg::OP_RELEASE, 3'd4, 8'h12);
        send_word(rlwq_pkg::OP_RELEASE, 3'd4, 8'hFF);
        send_word(rlwq_pkg::OP_RELEASE, 3'd4, 8'h12);
        send_word(rlwq_pkg::OP_RELEASE, 3'd4, 8'h12);
        send_word(rlwq_pkg::OP_RELEASE, 3'd0, 8'h00);
    endtask

    task automatic test_queue_full();
        send_word(rlwq_pkg::OP_REQUEST, 3'd2, 8'h80);
        for (int i = 0; i < rlwq_pkg::QUEUE_DEPTH; i++)
            send_word(rlwq_pkg::OP_REQUEST, 3'd2, 8'(i * 17 + 1));
        send_word(rlwq_pkg::OP_REQUEST, 3'd2, 8'h7F);
    endtask

    task automatic test_contention();
        run_traffic(160, $urandom_range(0, rlwq_pkg::NUM_RESOURCES - 1), 15);
    endtask

    task automatic test_mixed_traffic();
        run_traffic(330, -1, 40);
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        run_traffic(60, -1, 35);
    endtask

    // drive m_tready with random stall bursts
    initial
    begin
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready   <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        rlwq_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (lock_results.size() == 0)
            begin
                report_mismatch("unexpected result word", m_tdata, 0);
            end
            else
            begin
                want = lock_results.pop_front();
                if (m_tdata[0] !== want.granted)
                    report_mismatch("granted", m_tdata[0], want.granted);
                if (m_tdata[1] !== want.blocked)
                    report_mismatch("blocked", m_tdata[1], want.blocked);
                if (m_tdata[2] !== want.wake_valid)
                    report_mismatch("wake_valid", m_tdata[2], want.wake_valid);
                if (m_tdata[10:3] !== want.wake_id)
                    report_mismatch("wake_id", m_tdata[10:3], want.wake_id);
                if (m_tdata[12:11] !== want.status)
                    report_mismatch("status", m_tdata[12:11], want.status);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        idle_on     = 1'b1;
        for (int r = 0; r < rlwq_pkg::NUM_RESOURCES; r++)
        begin
            lock_busy[r]    = 1'b0;
            lock_owner[r]   = '0;
            waiter_head[r]  = 0;
            waiter_tail[r]  = 0;
            waiter_count[r] = 0;
        end
        for (int p = 0; p < POOL_SIZE; p++)
            pid_pool[p] = 8'($urandom_range(0, 255));
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_invalid_resource();
        test_grant_and_regrant();
        test_release_paths();
        test_queue_full();
        test_contention();
        test_mixed_traffic();
        test_steady_stream();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (lock_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/rlwq_pkg.sv
design/rlwq_ram.sv
design/rlwq_update.sv
design/resource_lock_with_wait_queues_core.sv
design/rlwq_checker.sv
sim/resource_lock_with_wait_queues_core_tb.sv
